// File: design/kli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_pkg: shared definitions of the keyframe linear interpolator
// Field widths, operation and result codes, the register map and the types
// that travel between the key store, the divider, the lerp unit and the top.
// ----------------------------------------------------------------------------
package kli_pkg;

   // Table size default and fixed field widths.
   localparam int DEFAULT_MAX_KEYS = 64;
   localparam int DATA_W           = 32;
   localparam int KEY_INDEX_W      = 6;
   localparam int KEY_COUNT_W      = 7;
   localparam int SEGMENT_W        = 6;
   localparam int HOW_W            = 2;
   localparam int LANES            = 3;
   localparam int FRAC_SHIFT       = 31;

   // Operation codes carried by the request beat.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // How the result was obtained.
   localparam logic [HOW_W-1:0] HOW_INTERP = 2'd0;
   localparam logic [HOW_W-1:0] HOW_FIRST  = 2'd1;
   localparam logic [HOW_W-1:0] HOW_LAST   = 2'd2;

   // Register map: one register, index taken from paddr[2].
   localparam int                     CSR_ADDR_W      = 3;
   localparam int                     CSR_DATA_W      = 32;
   localparam logic                   REG_KEY_COUNT   = 1'b0;
   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd1;

   // One vector of three components, lane 0 is x.
   typedef logic [LANES-1:0][DATA_W-1:0] vec_type;

   // Write port of the key store.
   typedef struct packed {
      logic                   en;
      logic [KEY_INDEX_W-1:0] index;
      logic [DATA_W-1:0]      key_time;
      vec_type                vec;
   } wr_type;

endpackage
`default_nettype wire

// File: design/kli_key_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_key_store: keyframe memories
// Holds the key times and the key vectors in two memories, each with a
// separate write and read address: one write and one registered read per
// cycle. Writes beyond the table are dropped.
// ----------------------------------------------------------------------------
module kli_key_store #(
   parameter int MAX_KEYS = kli_pkg::DEFAULT_MAX_KEYS
) (
   input  wire                          clock,
   input  kli_pkg::wr_type              wr,
   input  wire [$clog2(MAX_KEYS)-1:0]   rd_addr,
   output logic [kli_pkg::DATA_W-1:0]   rd_time,
   output kli_pkg::vec_type             rd_vec
);

   localparam int IDX_W = $clog2(MAX_KEYS);

   logic [kli_pkg::DATA_W-1:0] time_mem [MAX_KEYS];
   kli_pkg::vec_type           vec_mem  [MAX_KEYS];
   logic [kli_pkg::DATA_W-1:0] rd_time_ff;
   kli_pkg::vec_type           rd_vec_ff;
   logic                       wr_hit;
   logic [IDX_W-1:0]           wr_addr;

   // A write whose index lies beyond the table has no effect.
   assign wr_hit  = wr.en && (32'(wr.index) < MAX_KEYS);
   assign wr_addr = IDX_W'(wr.index);

   // Time memory.
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         time_mem[wr_addr] <= wr.key_time;
      end
      rd_time_ff <= time_mem[rd_addr];
   end

   // Vector memory.
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         vec_mem[wr_addr] <= wr.vec;
      end
      rd_vec_ff <= vec_mem[rd_addr];
   end

   assign rd_time = rd_time_ff;
   assign rd_vec  = rd_vec_ff;

endmodule
`default_nettype wire

// File: design/kli_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_divider: serial fraction divider
// Computes floor(num * 2^31 / den) for num <= den, den nonzero, as a Q1.31
// fraction. Restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kli_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [kli_pkg::DATA_W-1:0]    num,
   input  wire [kli_pkg::DATA_W-1:0]    den,
   output logic                         done,
   output logic [kli_pkg::DATA_W-1:0]   quot
);

   localparam int W     = kli_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic             bit_ff, bit_in;
   logic [W:0]       trial;
   logic [W:0]       diff;
   logic             fits;

   // One step: bring down the next dividend bit and try to subtract.
   assign trial = {rem_ff, bit_ff};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      if (start) begin
         // The dividend is num shifted up by 31: its top word is num / 2
         // and its only other set bit is the low bit of num.
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num[W-1:1]};
         bit_in  = num[0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         bit_in = 1'b0;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
`default_nettype wire

// File: design/kli_lerp_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_lerp_unit: shared interpolation datapath
// One subtractor, one 33 x 33 multiplier and one adder are used in turn for
// the three components: a + floor((b - a) * f / 2^31). Each component passes
// through a difference, a multiply and an add phase in that order.
// ----------------------------------------------------------------------------
module kli_lerp_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  kli_pkg::vec_type             a_vec,
   input  kli_pkg::vec_type             b_vec,
   input  wire [kli_pkg::DATA_W-1:0]    frac,
   output logic                         done,
   output kli_pkg::vec_type             res_vec
);

   localparam int W = kli_pkg::DATA_W;

   localparam logic [1:0] PH_DIFF = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ADD  = 2'd2;

   localparam logic [1:0] LAST_LANE = 2'(kli_pkg::LANES - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [1:0]              phase_ff, phase_in;
   logic [1:0]              lane_ff, lane_in;
   kli_pkg::vec_type        a_ff, a_in;
   kli_pkg::vec_type        b_ff, b_in;
   logic [W-1:0]            f_ff, f_in;
   logic signed [W:0]       d_ff, d_in;
   logic [W-1:0]            p_ff, p_in;
   kli_pkg::vec_type        res_ff, res_in;
   logic signed [2*W+1:0]   product;

   // Signed difference times the unsigned fraction; the arithmetic shift
   // by 31 is a floor, and only its low word is kept.
   assign product = d_ff * $signed({1'b0, f_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      lane_in  = lane_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      f_in     = f_ff;
      d_in     = d_ff;
      p_in     = p_ff;
      res_in   = res_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_DIFF;
         lane_in  = '0;
         a_in     = a_vec;
         b_in     = b_vec;
         f_in     = frac;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_DIFF: begin
               d_in     = $signed({b_ff[lane_ff][W-1], b_ff[lane_ff]}
                                  - {a_ff[lane_ff][W-1], a_ff[lane_ff]});
               phase_in = PH_MUL;
            end
            PH_MUL: begin
               p_in     = product[kli_pkg::FRAC_SHIFT +: W];
               phase_in = PH_ADD;
            end
            PH_ADD: begin
               res_in[lane_ff] = a_ff[lane_ff] + p_ff;
               phase_in        = PH_DIFF;
               if (lane_ff == LAST_LANE) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  lane_in = lane_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_DIFF;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_DIFF;
         lane_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         lane_ff  <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      f_ff   <= f_in;
      d_ff   <= d_in;
      p_ff   <= p_in;
      res_ff <= res_in;
   end

   assign done    = done_ff;
   assign res_vec = res_ff;

endmodule
`default_nettype wire

// File: design/keyframe_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// A query scans one key time a cycle, then, for an enclosing segment of nonzero
// length, runs the serial division, and an interpolated result goes through
// the shared multiply unit. The block takes one request at a time; req_ready
// is high only when the sequencer is idle. Synchronous active-high reset sets
// key_count to one and empties the response register; the key memories are
// not cleared.
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator: keyframe table with linear interpolation
// Stores up to MAX_KEYS keyframes and answers time queries with the
// interpolated vector of the first enclosing segment, or a held end value.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
   parameter int MAX_KEYS = kli_pkg::DEFAULT_MAX_KEYS
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // Request channel
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire                                    req_opcode,
   input  wire [kli_pkg::KEY_INDEX_W-1:0]         req_key_index,
   input  wire [kli_pkg::DATA_W-1:0]              req_key_time,
   input  wire signed [kli_pkg::DATA_W-1:0]       req_key_x,
   input  wire signed [kli_pkg::DATA_W-1:0]       req_key_y,
   input  wire signed [kli_pkg::DATA_W-1:0]       req_key_z,
   input  wire [kli_pkg::DATA_W-1:0]              req_query_time,
   // Response channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic signed [kli_pkg::DATA_W-1:0]      rsp_out_x,
   output logic signed [kli_pkg::DATA_W-1:0]      rsp_out_y,
   output logic signed [kli_pkg::DATA_W-1:0]      rsp_out_z,
   output logic [kli_pkg::SEGMENT_W-1:0]          rsp_segment,
   output logic [kli_pkg::HOW_W-1:0]              rsp_how_found,
   // Register port
   input  wire                                    psel,
   input  wire                                    penable,
   input  wire                                    pwrite,
   input  wire [kli_pkg::CSR_ADDR_W-1:0]          paddr,
   input  wire [kli_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [kli_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int W     = kli_pkg::DATA_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN0 = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_VEC_A = 3'd4;
   localparam logic [2:0] ST_VEC_B = 3'd5;
   localparam logic [2:0] ST_LERP  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [kli_pkg::KEY_COUNT_W-1:0]   key_count_ff, key_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                      q_ff, q_in;
   logic [CNT_W-1:0]                  n_ff, n_in;
   logic [CNT_W-1:0]                  n_clamped;
   logic [W-1:0]                      prev_ff, prev_in;
   logic [IDX_W-1:0]                  i_ff, i_in;
   logic [IDX_W-1:0]                  seg_ff, seg_in;
   logic [IDX_W-1:0]                  b_ff, b_in;
   logic [kli_pkg::HOW_W-1:0]         how_ff, how_in;
   logic [W-1:0]                      f_ff, f_in;
   kli_pkg::vec_type                  a_ff, a_in;
   kli_pkg::vec_type                  res_ff, res_in;
   kli_pkg::vec_type                  rsp_vec_ff, rsp_vec_in;
   logic [kli_pkg::SEGMENT_W-1:0]     rsp_seg_ff, rsp_seg_in;
   logic [kli_pkg::HOW_W-1:0]         rsp_how_ff, rsp_how_in;

   logic                              accept;
   logic                              csr_write;
   kli_pkg::wr_type                   wr;
   logic [IDX_W-1:0]                  rd_addr;
   logic [W-1:0]                      rd_time;
   kli_pkg::vec_type                  rd_vec;
   logic                              div_start;
   logic [W-1:0]                      div_num;
   logic [W-1:0]                      div_den;
   logic                              div_done;
   logic [W-1:0]                      div_quot;
   logic                              lerp_start;
   logic                              lerp_done;
   kli_pkg::vec_type                  lerp_res;
   logic                              enclosed;
   logic                              last_pair;
   logic                              out_free;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[kli_pkg::CSR_ADDR_W-1] == kli_pkg::REG_KEY_COUNT);
   assign key_count_in = csr_write ? pwdata[kli_pkg::KEY_COUNT_W-1:0] : key_count_ff;
   assign prdata = (paddr[kli_pkg::CSR_ADDR_W-1] == kli_pkg::REG_KEY_COUNT)
                   ? kli_pkg::CSR_DATA_W'(key_count_ff) : '0;

   // Keys in use, limited to one at the bottom and the table size on top.
   always_comb begin
      if (key_count_ff == '0) begin
         n_clamped = CNT_W'(1);
      end else if (32'(key_count_ff) > MAX_KEYS) begin
         n_clamped = CNT_W'(MAX_KEYS);
      end else begin
         n_clamped = CNT_W'(key_count_ff);
      end
   end

   // ------------------------------------------------------------------
   // Request handshake and key writes
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign wr.en       = accept && (req_opcode == kli_pkg::OP_WRITE);
   assign wr.index    = req_key_index;
   assign wr.key_time = req_key_time;
   assign wr.vec      = {req_key_z, req_key_y, req_key_x};

   kli_key_store #(
      .MAX_KEYS (MAX_KEYS)
   ) u_key_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_time (rd_time),
      .rd_vec  (rd_vec)
   );

   kli_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   kli_lerp_unit u_lerp_unit (
      .clock   (clock),
      .reset   (reset),
      .start   (lerp_start),
      .a_vec   (a_ff),
      .b_vec   (rd_vec),
      .frac    (f_ff),
      .done    (lerp_done),
      .res_vec (lerp_res)
   );

   // Segment test on the previous and the current key time.
   assign enclosed  = (prev_ff <= q_ff) && (q_ff <= rd_time);
   assign last_pair = ((CNT_W'(i_ff) + CNT_W'(1)) == (n_ff - CNT_W'(1)));
   assign div_num   = q_ff - prev_ff;
   assign div_den   = rd_time - prev_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      prev_in      = prev_ff;
      i_in         = i_ff;
      seg_in       = seg_ff;
      b_in         = b_ff;
      how_in       = how_ff;
      f_in         = f_ff;
      a_in         = a_ff;
      res_in       = res_ff;
      rsp_vec_in   = rsp_vec_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_how_in   = rsp_how_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      div_start    = 1'b0;
      lerp_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // A query latches its time and the key count, and reads key 0.
            if (accept && (req_opcode == kli_pkg::OP_QUERY)) begin
               q_in     = req_query_time;
               n_in     = n_clamped;
               state_in = ST_SCAN0;
            end
         end
         ST_SCAN0: begin
            prev_in = rd_time;
            if ((n_ff == CNT_W'(1)) || (q_ff <= rd_time)) begin
               seg_in   = '0;
               b_in     = '0;
               how_in   = kli_pkg::HOW_FIRST;
               state_in = ST_VEC_B;
            end else begin
               i_in     = '0;
               rd_addr  = IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // One segment a cycle: previous time against the time just read.
            if (enclosed) begin
               seg_in = i_ff;
               b_in   = i_ff + IDX_W'(1);
               how_in = kli_pkg::HOW_INTERP;
               if (div_den == '0) begin
                  f_in     = '0;
                  rd_addr  = i_ff;
                  state_in = ST_VEC_A;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else if (last_pair) begin
               seg_in   = IDX_W'(n_ff - CNT_W'(1));
               b_in     = IDX_W'(n_ff - CNT_W'(1));
               how_in   = kli_pkg::HOW_LAST;
               rd_addr  = IDX_W'(n_ff - CNT_W'(1));
               state_in = ST_VEC_B;
            end else begin
               prev_in = rd_time;
               i_in    = i_ff + IDX_W'(1);
               rd_addr = IDX_W'(CNT_W'(i_ff) + CNT_W'(2));
            end
         end
         ST_DIV: begin
            if (div_done) begin
               f_in     = div_quot;
               rd_addr  = seg_ff;
               state_in = ST_VEC_A;
            end
         end
         ST_VEC_A: begin
            a_in     = rd_vec;
            rd_addr  = b_ff;
            state_in = ST_VEC_B;
         end
         ST_VEC_B: begin
            // Held values go straight out; segments go through the lerp unit.
            if (how_ff == kli_pkg::HOW_INTERP) begin
               lerp_start = 1'b1;
               state_in   = ST_LERP;
            end else begin
               res_in   = rd_vec;
               state_in = ST_DONE;
            end
         end
         ST_LERP: begin
            if (lerp_done) begin
               res_in   = lerp_res;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Move the result into the response register once it is free.
            if (out_free) begin
               rsp_vec_in   = res_ff;
               rsp_seg_in   = kli_pkg::SEGMENT_W'(seg_ff);
               rsp_how_in   = how_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= kli_pkg::KEY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      n_ff       <= n_in;
      prev_ff    <= prev_in;
      i_ff       <= i_in;
      seg_ff     <= seg_in;
      b_ff       <= b_in;
      how_ff     <= how_in;
      f_ff       <= f_in;
      a_ff       <= a_in;
      res_ff     <= res_in;
      rsp_vec_ff <= rsp_vec_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_how_ff <= rsp_how_in;
   end

   // Response beat.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = $signed(rsp_vec_ff[0]);
   assign rsp_out_y     = $signed(rsp_vec_ff[1]);
   assign rsp_out_z     = $signed(rsp_vec_ff[2]);
   assign rsp_segment   = rsp_seg_ff;
   assign rsp_how_found = rsp_how_ff;

endmodule
`default_nettype wire

// File: design/kli_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_checker: port-level checks of the keyframe linear interpolator
// Watches the request, response and register ports and is bound to the top.
// ----------------------------------------------------------------------------
module kli_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 req_opcode,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire [kli_pkg::DATA_W-1:0]           rsp_out_x,
   input wire [kli_pkg::DATA_W-1:0]           rsp_out_y,
   input wire [kli_pkg::DATA_W-1:0]           rsp_out_z,
   input wire [kli_pkg::SEGMENT_W-1:0]        rsp_segment,
   input wire [kli_pkg::HOW_W-1:0]            rsp_how_found,
   input wire                                 psel,
   input wire                                 penable,
   input wire                                 pwrite,
   input wire                                 pready,
   input wire [kli_pkg::CSR_ADDR_W-1:0]       paddr,
   input wire [kli_pkg::CSR_DATA_W-1:0]       pwdata,
   input wire [kli_pkg::CSR_DATA_W-1:0]       prdata
);

   // After reset the block is idle with no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A pending response beat holds still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z)
         && $stable(rsp_segment) && $stable(rsp_how_found))
      else $error("response beat changed while stalled");

   // A key write never produces a response beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == kli_pkg::OP_WRITE)
         |=> !$rose(rsp_valid))
      else $error("response produced by a key write");

   // Accepting a query takes the sequencer out of idle, so req_ready falls.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == kli_pkg::OP_QUERY) |=> !req_ready)
      else $error("request taken while a query is in progress");

   // The key count reads back what was last written.
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready
         && (paddr[kli_pkg::CSR_ADDR_W-1] == kli_pkg::REG_KEY_COUNT)
         |=> (paddr[kli_pkg::CSR_ADDR_W-1] != kli_pkg::REG_KEY_COUNT)
            || (prdata[kli_pkg::KEY_COUNT_W-1:0]
                == $past(pwdata[kli_pkg::KEY_COUNT_W-1:0])))
      else $error("key count read-back mismatch");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_opcode    (req_opcode),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .rsp_segment   (rsp_segment),
   .rsp_how_found (rsp_how_found),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .pready        (pready),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata)
);
`default_nettype wire
